/* sv/pfd_pkg.sv */
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared widths, register indexes, datapath operation codes and helpers.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int DATA_W   = 32;
    localparam int FRAC     = 16;
    localparam int SLOPE_W  = 48;
    localparam int DIVN_W   = 49;
    localparam int DIVD_W   = 33;
    localparam int ALPHA_W  = 17;
    localparam int CAP_W    = 37;
    localparam int ADDR_W   = 5;
    localparam int STEP_W   = 5;

    localparam logic [2:0] REG_GAIN_P   = 3'd0;
    localparam logic [2:0] REG_GAIN_I   = 3'd1;
    localparam logic [2:0] REG_GAIN_D   = 3'd2;
    localparam logic [2:0] REG_INT_LIM  = 3'd3;
    localparam logic [2:0] REG_DER_LIM  = 3'd4;
    localparam logic [2:0] REG_DEADBAND = 3'd5;
    localparam logic [2:0] REG_TAU      = 3'd6;

    localparam logic [30:0] DER_LIM_RESET = 31'd655360;
    localparam logic [15:0] TAU_RESET     = 16'd522;

    localparam logic [4:0] OP_NONE       = 5'd0;
    localparam logic [4:0] OP_LOAD       = 5'd1;
    localparam logic [4:0] OP_MUL_P      = 5'd2;
    localparam logic [4:0] OP_TAKE_P     = 5'd3;
    localparam logic [4:0] OP_MUL_IA     = 5'd4;
    localparam logic [4:0] OP_TAKE_IA    = 5'd5;
    localparam logic [4:0] OP_MUL_IB     = 5'd6;
    localparam logic [4:0] OP_TAKE_IB    = 5'd7;
    localparam logic [4:0] OP_MUL_IC     = 5'd8;
    localparam logic [4:0] OP_TAKE_IC    = 5'd9;
    localparam logic [4:0] OP_INTEG      = 5'd10;
    localparam logic [4:0] OP_DIV_SLOPE  = 5'd11;
    localparam logic [4:0] OP_TAKE_SLOPE = 5'd12;
    localparam logic [4:0] OP_DIV_ALPHA  = 5'd13;
    localparam logic [4:0] OP_TAKE_ALPHA = 5'd14;
    localparam logic [4:0] OP_DELTA      = 5'd15;
    localparam logic [4:0] OP_MUL_FA     = 5'd16;
    localparam logic [4:0] OP_TAKE_FA    = 5'd17;
    localparam logic [4:0] OP_MUL_FB     = 5'd18;
    localparam logic [4:0] OP_TAKE_FB    = 5'd19;
    localparam logic [4:0] OP_FILT       = 5'd20;
    localparam logic [4:0] OP_MUL_DA     = 5'd21;
    localparam logic [4:0] OP_TAKE_DA    = 5'd22;
    localparam logic [4:0] OP_MUL_DB     = 5'd23;
    localparam logic [4:0] OP_TAKE_DB    = 5'd24;
    localparam logic [4:0] OP_DCLAMP     = 5'd25;
    localparam logic [4:0] OP_SUM        = 5'd26;

    typedef struct packed {
        logic [4:0] op;
    } pfd_cmd_t;

    typedef struct packed {
        logic div_done;
    } pfd_status_t;

    typedef struct packed {
        logic [31:0] gain_p;
        logic [31:0] gain_i;
        logic [31:0] gain_d;
        logic [30:0] int_lim;
        logic [30:0] der_lim;
        logic [14:0] deadband;
        logic [15:0] tau;
    } pfd_cfg_t;

    // Operation issued at each step of the per-request program.
    function automatic logic [4:0] op_at(input logic [STEP_W-1:0] step);
        logic [4:0] op;
        case (step)
            5'd0:    op = OP_MUL_P;
            5'd1:    op = OP_TAKE_P;
            5'd2:    op = OP_MUL_IA;
            5'd3:    op = OP_TAKE_IA;
            5'd4:    op = OP_MUL_IB;
            5'd5:    op = OP_TAKE_IB;
            5'd6:    op = OP_MUL_IC;
            5'd7:    op = OP_TAKE_IC;
            5'd8:    op = OP_INTEG;
            5'd9:    op = OP_DIV_SLOPE;
            5'd10:   op = OP_TAKE_SLOPE;
            5'd11:   op = OP_DIV_ALPHA;
            5'd12:   op = OP_TAKE_ALPHA;
            5'd13:   op = OP_DELTA;
            5'd14:   op = OP_MUL_FA;
            5'd15:   op = OP_TAKE_FA;
            5'd16:   op = OP_MUL_FB;
            5'd17:   op = OP_TAKE_FB;
            5'd18:   op = OP_FILT;
            5'd19:   op = OP_MUL_DA;
            5'd20:   op = OP_TAKE_DA;
            5'd21:   op = OP_MUL_DB;
            5'd22:   op = OP_TAKE_DB;
            5'd23:   op = OP_DCLAMP;
            5'd24:   op = OP_SUM;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

    // Saturate a magnitude at 2^36.
    function automatic logic [CAP_W-1:0] cap36(input logic [63:0] x);
        logic [CAP_W-1:0] r;
        if (x > 64'h10_0000_0000)
            r = 37'h10_0000_0000;
        else
            r = x[CAP_W-1:0];
        return r;
    endfunction

endpackage

/* sv/pfd_div.sv */
// ----------------------------------------------------------------------------
// pfd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfd_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [pfd_pkg::DIVN_W-1:0]  dividend,
    input  logic [pfd_pkg::DIVD_W-1:0]  divisor,
    output logic [pfd_pkg::DIVN_W-1:0]  quotient,
    output logic                        done
);
    import pfd_pkg::*;

    logic [DIVN_W-1:0] q_reg;
    logic [DIVD_W-1:0] rem_reg;
    logic [DIVD_W-1:0] dvs_reg;
    logic [5:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIVD_W:0]   rem_sh;
    logic [DIVD_W+1:0] trial;

    assign rem_sh = {rem_reg, q_reg[DIVN_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == 6'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'(DIVN_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DIVD_W+1])
            begin
                rem_reg <= trial[DIVD_W-1:0];
                q_reg   <= {q_reg[DIVN_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DIVD_W-1:0];
                q_reg   <= {q_reg[DIVN_W-2:0], 1'b0};
            end
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

/* sv/pfd_ctrl.sv */
// ----------------------------------------------------------------------------
// pfd_ctrl
// Sequencer: steps the datapath through the per-request operation program.
// ----------------------------------------------------------------------------
module pfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  pfd_pkg::pfd_status_t status,
    output pfd_pkg::pfd_cmd_t    cmd
);
    import pfd_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              ov_reg, ov_next;
    logic [4:0]        prog_op;

    assign prog_op = op_at(step_reg);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        ov_next    = ov_reg && out_stall;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // The final sum waits until the output register is free.
                if (prog_op == OP_SUM)
                begin
                    if (!(ov_reg && out_stall))
                    begin
                        cmd.op     = OP_SUM;
                        ov_next    = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.op    = prog_op;
                    step_next = step_reg + 5'd1;
                    if (prog_op == OP_DIV_SLOPE || prog_op == OP_DIV_ALPHA)
                        state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (status.div_done)
                    state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = ov_reg;

endmodule

/* sv/pfd_dp.sv */
// ----------------------------------------------------------------------------
// pfd_dp
// Datapath: shared 32x32 multiplier, divider, term registers and state.
// ----------------------------------------------------------------------------
module pfd_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfd_pkg::pfd_cmd_t    cmd,
    input  pfd_pkg::pfd_cfg_t    cfg,
    input  logic signed [31:0]   goal_value,
    input  logic signed [31:0]   error_value,
    input  logic [31:0]          time_step,
    output pfd_pkg::pfd_status_t status,
    output logic signed [31:0]   drive
);
    import pfd_pkg::*;

    // Architectural state.
    logic [31:0]        acc_reg;
    logic [31:0]        prev_reg;
    logic [SLOPE_W-1:0] fs_reg;

    // Per-request working registers.
    logic [31:0]        goal_reg;
    logic [31:0]        err_reg;
    logic [31:0]        dt_reg;
    logic [63:0]        prod_reg;
    logic [63:0]        t_reg;
    logic [62:0]        ia_reg;
    logic [47:0]        m_reg;
    logic [37:0]        p_reg;
    logic [SLOPE_W-1:0] slope_reg;
    logic [ALPHA_W-1:0] alpha_reg;
    logic [47:0]        dmag_reg;
    logic               dneg_reg;
    logic [31:0]        d_reg;
    logic [31:0]        drive_reg;

    logic [31:0] mul_a, mul_b;
    logic [31:0] in_err_mag, err_mag, gp_mag, gi_mag, gd_mag;
    logic [46:0] fs_mag;
    logic        neg_p, neg_i, neg_d;
    logic [32:0] diff;
    logic [32:0] diff_mag;

    logic              div_start;
    logic [DIVN_W-1:0] div_n;
    logic [DIVD_W-1:0] div_d;
    logic [DIVN_W-1:0] div_q;
    logic              div_done;

    logic [63:0]        i_wide;
    logic [49:0]        f_wide;
    logic [63:0]        d_wide;
    logic [CAP_W-1:0]   p_cap;
    logic [37:0]        i_add;
    logic signed [37:0] i_sum;
    logic signed [37:0] ilim_s;
    logic [SLOPE_W-1:0] slope_sat;
    logic [48:0]        delta;
    logic [37:0]        d_sgn;
    logic signed [37:0] dlim_s;
    logic signed [38:0] total;

    function automatic logic [31:0] abs32(input logic [31:0] x);
        return x[31] ? (32'd0 - x) : x;
    endfunction

    assign in_err_mag = abs32(error_value);
    assign err_mag    = abs32(err_reg);
    assign gp_mag     = abs32(cfg.gain_p);
    assign gi_mag     = abs32(cfg.gain_i);
    assign gd_mag     = abs32(cfg.gain_d);
    assign fs_mag     = fs_reg[SLOPE_W-1] ? 47'(48'd0 - fs_reg) : fs_reg[46:0];
    assign neg_p      = cfg.gain_p[31] ^ err_reg[31];
    assign neg_i      = cfg.gain_i[31] ^ err_reg[31];
    assign neg_d      = cfg.gain_d[31] ^ fs_reg[SLOPE_W-1];
    assign diff       = {goal_reg[31], goal_reg} - {prev_reg[31], prev_reg};
    assign diff_mag   = diff[32] ? (33'd0 - diff) : diff;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_P:
            begin
                mul_a = gp_mag;
                mul_b = err_mag;
            end
            OP_MUL_IA:
            begin
                mul_a = gi_mag;
                mul_b = err_mag;
            end
            OP_MUL_IB:
            begin
                mul_a = ia_reg[31:0];
                mul_b = dt_reg;
            end
            OP_MUL_IC:
            begin
                mul_a = {1'b0, ia_reg[62:32]};
                mul_b = dt_reg;
            end
            OP_MUL_FA:
            begin
                mul_a = dmag_reg[31:0];
                mul_b = {15'b0, alpha_reg};
            end
            OP_MUL_FB:
            begin
                mul_a = {16'b0, dmag_reg[47:32]};
                mul_b = {15'b0, alpha_reg};
            end
            OP_MUL_DA:
            begin
                mul_a = fs_mag[31:0];
                mul_b = gd_mag;
            end
            OP_MUL_DB:
            begin
                mul_a = {17'b0, fs_mag[46:32]};
                mul_b = gd_mag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Divider operands: raw slope first, then the filter coefficient.
    assign div_start = (cmd.op == OP_DIV_SLOPE) || (cmd.op == OP_DIV_ALPHA);
    assign div_n = (cmd.op == OP_DIV_SLOPE) ? {diff_mag, 16'b0} : {1'b0, dt_reg, 16'b0};
    assign div_d = (cmd.op == OP_DIV_SLOPE) ? {1'b0, dt_reg}
                                            : ({17'b0, cfg.tau} + {1'b0, dt_reg});

    pfd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .quotient (div_q),
        .done     (div_done)
    );

    assign status.div_done = div_done;

    // Combining the upper and lower partial products, each floor-shifted.
    assign i_wide = prod_reg + {32'b0, t_reg[63:32]};
    assign f_wide = {prod_reg[33:0], 16'b0} + {2'b0, t_reg[63:16]};
    assign d_wide = {prod_reg[47:0], 16'b0} + {16'b0, t_reg[63:16]};
    assign p_cap  = cap36({16'b0, prod_reg[63:16]});

    assign i_add  = neg_i ? (38'd0 - {1'b0, m_reg[36:0]}) : {1'b0, m_reg[36:0]};
    assign i_sum  = $signed({{6{acc_reg[31]}}, acc_reg}) + $signed(i_add);
    assign ilim_s = $signed({7'b0, cfg.int_lim});

    assign slope_sat = (div_q > {2'b0, {47{1'b1}}}) ? {1'b0, {47{1'b1}}}
                                                    : div_q[SLOPE_W-1:0];
    assign delta     = {slope_reg[SLOPE_W-1], slope_reg} - {fs_reg[SLOPE_W-1], fs_reg};

    assign d_sgn  = neg_d ? (38'd0 - {1'b0, m_reg[36:0]}) : {1'b0, m_reg[36:0]};
    assign dlim_s = $signed({7'b0, cfg.der_lim});

    assign total = $signed({p_reg[37], p_reg})
                 + $signed({{7{acc_reg[31]}}, acc_reg})
                 + $signed({{7{d_reg[31]}}, d_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            prev_reg <= '0;
            fs_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_INTEG:
                begin
                    if (i_sum > ilim_s)
                        acc_reg <= {1'b0, cfg.int_lim};
                    else if (i_sum < -ilim_s)
                        acc_reg <= 32'd0 - {1'b0, cfg.int_lim};
                    else
                        acc_reg <= i_sum[31:0];
                end
                OP_FILT:
                begin
                    fs_reg   <= dneg_reg ? (fs_reg - m_reg) : (fs_reg + m_reg);
                    prev_reg <= goal_reg;
                end
                default:
                begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_LOAD:
            begin
                goal_reg <= goal_value;
                dt_reg   <= (time_step == 32'd0) ? 32'd1 : time_step;
                // Errors inside the deadband count as zero.
                if (in_err_mag < {1'b0, cfg.deadband, 16'b0})
                    err_reg <= '0;
                else
                    err_reg <= error_value;
            end
            OP_TAKE_P:     p_reg <= neg_p ? (38'd0 - {1'b0, p_cap}) : {1'b0, p_cap};
            OP_TAKE_IA:    ia_reg <= prod_reg[62:0];
            OP_TAKE_IB:    t_reg <= prod_reg;
            OP_TAKE_IC:    m_reg <= {11'b0, cap36(i_wide)};
            OP_TAKE_SLOPE: slope_reg <= diff[32] ? (48'd0 - slope_sat) : slope_sat;
            OP_TAKE_ALPHA: alpha_reg <= div_q[ALPHA_W-1:0];
            OP_DELTA:
            begin
                dneg_reg <= delta[48];
                dmag_reg <= delta[48] ? 48'(49'd0 - delta) : delta[47:0];
            end
            OP_TAKE_FA:    t_reg <= prod_reg;
            OP_TAKE_FB:    m_reg <= f_wide[47:0];
            OP_TAKE_DA:    t_reg <= prod_reg;
            OP_TAKE_DB:    m_reg <= {11'b0, cap36(d_wide)};
            OP_DCLAMP:
            begin
                if ($signed(d_sgn) > dlim_s)
                    d_reg <= {1'b0, cfg.der_lim};
                else if ($signed(d_sgn) < -dlim_s)
                    d_reg <= 32'd0 - {1'b0, cfg.der_lim};
                else
                    d_reg <= d_sgn[31:0];
            end
            OP_SUM:
            begin
                if (total > 39'sh007FFFFFFF)
                    drive_reg <= 32'h7FFF_FFFF;
                else if (total < -39'sh0080000000)
                    drive_reg <= 32'h8000_0000;
                else
                    drive_reg <= total[31:0];
            end
            default:
            begin
                t_reg <= t_reg;
            end
        endcase
    end

    assign drive = drive_reg;

endmodule

/* sv/pid_filtered_derivative_top.sv */
// ----------------------------------------------------------------------------
// pid_filtered_derivative_top: PID controller with low-pass filtered derivative
// Each request runs 25 program steps on one 32x32 multiplier, and two of them wait
// on the divider (49 quotient bits and a done strobe). One request is in flight:
// no new request is taken until the final sum is issued, and a stalled result
// holds the final step until the output register is free.
// Reset clears integrator, previous goal and filter state; registers to defaults.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pfd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          goal_value,
    input  logic signed [31:0]          error_value,
    input  logic [31:0]                 time_step,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          drive
);
    import pfd_pkg::*;

    pfd_cfg_t    cfg_reg;
    pfd_cmd_t    cmd;
    pfd_status_t status;
    logic [2:0]  reg_idx;
    logic        wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p   <= '0;
            cfg_reg.gain_i   <= '0;
            cfg_reg.gain_d   <= '0;
            cfg_reg.int_lim  <= '0;
            cfg_reg.der_lim  <= DER_LIM_RESET;
            cfg_reg.deadband <= '0;
            cfg_reg.tau      <= TAU_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_GAIN_P:   cfg_reg.gain_p   <= pwdata;
                REG_GAIN_I:   cfg_reg.gain_i   <= pwdata;
                REG_GAIN_D:   cfg_reg.gain_d   <= pwdata;
                REG_INT_LIM:  cfg_reg.int_lim  <= pwdata[30:0];
                REG_DER_LIM:  cfg_reg.der_lim  <= pwdata[30:0];
                REG_DEADBAND: cfg_reg.deadband <= pwdata[14:0];
                REG_TAU:      cfg_reg.tau      <= pwdata[15:0];
                default:      cfg_reg.tau      <= cfg_reg.tau;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GAIN_P:   prdata = cfg_reg.gain_p;
            REG_GAIN_I:   prdata = cfg_reg.gain_i;
            REG_GAIN_D:   prdata = cfg_reg.gain_d;
            REG_INT_LIM:  prdata = {1'b0, cfg_reg.int_lim};
            REG_DER_LIM:  prdata = {1'b0, cfg_reg.der_lim};
            REG_DEADBAND: prdata = {17'b0, cfg_reg.deadband};
            REG_TAU:      prdata = {16'b0, cfg_reg.tau};
            default:      prdata = '0;
        endcase
    end

    pfd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    pfd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg_reg),
        .goal_value  (goal_value),
        .error_value (error_value),
        .time_step   (time_step),
        .status      (status),
        .drive       (drive)
    );

`ifndef SYNTHESIS
    // A request that is taken blocks the input until its result is computed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not blocked after a request was taken");

    // A new result is produced only as the sequencer returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("result raised while a request is still in progress");

    // The divider never finishes while the sequencer is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> in_stall)
        else $error("divider finished with no request in progress");
`endif

endmodule
